FILE: rtl/int_to_ascii_dec_hex_defines.svh
// Assertion macros for the binary to ASCII converter.
`ifndef INT_TO_ASCII_DEC_HEX_DEFINES_SVH
`define INT_TO_ASCII_DEC_HEX_DEFINES_SVH

// Same-cycle implication, checked on clk_i, off during reset.
`define ITAD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("itad: same-cycle check failed");

// Next-cycle implication, checked on clk_i, off during reset.
`define ITAD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("itad: next-cycle check failed");

`endif

FILE: rtl/itad_pkg.sv
// Shared constants and helpers for the binary to ASCII converter.
`default_nettype none
package itad_pkg;

  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_MINUS  = 8'h2d;

  localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
  localparam logic [3:0] BCD_ADJ       = 4'd3;
  localparam logic [3:0] DEC_RADIX     = 4'd10;

  localparam logic RADIX_DEC = 1'b0;
  localparam logic RADIX_HEX = 1'b1;

  // Map one digit 0..15 to lowercase ASCII.
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < DEC_RADIX) begin
      c = CHAR_ZERO + {4'd0, d};
    end else begin
      c = CHAR_LOWER_A + {4'd0, d - DEC_RADIX};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/int_to_ascii_dec_hex.sv
// Top level: binary word to ASCII decimal or hex characters, at most one per cycle.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------
//  input    | start / busy       | value_i, radix_mode_i
//  result   | valid_o (strobe)   | ascii_char_o, last_char_o
//
// A word is taken when start is high and busy is low. Decimal words pass
// through the shared shift-and-add-3 unit, go through the sign state for '-'
// when negative, then walk the NDIG digit slots: leading zero
// slots are dropped one a cycle, each digit leaves one a cycle.
// Hex words skip the conversion and go straight to the digit slots. Busy
// stays high until the last character of a word is sent, so a new word is
// taken only after the previous one is done, back in idle.
// Reset returns to idle; the receiver cannot stall, each
// character is shown for one cycle.
`default_nettype none
`include "int_to_ascii_dec_hex_defines.svh"
module int_to_ascii_dec_hex #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  input  wire logic                   radix_mode_i,
  output logic                        valid_o,
  output logic [7:0]                  ascii_char_o,
  output logic                        last_char_o
);
  import itad_pkg::*;

  localparam int unsigned NDEC = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int unsigned NHEX = (VALUE_WIDTH + 3) / 4;
  localparam int unsigned NDIG = (NDEC > NHEX) ? NDEC : NHEX;
  localparam int unsigned BW   = 4 * NDIG;
  localparam int unsigned CW   = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned RW   = $clog2(NDIG + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [BW-1:0]          bcd_q, bcd_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [RW-1:0]          rem_q, rem_d;
  logic                   started_q, started_d;
  logic                   valid_q, valid_d;
  logic                   last_q, last_d;
  logic [7:0]             char_q, char_d;

  logic [VALUE_WIDTH-1:0] mag;
  logic                   is_neg;
  logic [BW-1:0]          step_bcd;
  logic [3:0]             top_dig;

  // Shared conversion unit, one input bit a cycle.
  itad_dd_step #(.NDIG(NDIG)) u_step (
    .bcd_i (bcd_q),
    .bit_i (bin_q[VALUE_WIDTH-1]),
    .bcd_o (step_bcd)
  );

  // Magnitude of the incoming word.
  assign is_neg  = (radix_mode_i == RADIX_DEC) && value_i[VALUE_WIDTH-1];
  assign mag     = is_neg ? (~value_i + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : value_i;
  assign top_dig = bcd_q[BW-1 -: 4];

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    started_d = started_q;
    valid_d   = 1'b0;
    last_d    = 1'b0;
    char_d    = char_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          started_d = 1'b0;
          rem_d     = RW'(NDIG);
          if (radix_mode_i == RADIX_HEX) begin
            bcd_d   = BW'(value_i);
            state_d = ST_OUT;
          end else begin
            bin_d   = mag;
            bcd_d   = '0;
            cnt_d   = CW'(VALUE_WIDTH);
            state_d = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        bcd_d = step_bcd;
        bin_d = bin_q << 1;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          state_d = started_q ? ST_SIGN : ST_OUT;
        end
      end
      ST_SIGN: begin
        valid_d = 1'b1;
        char_d  = CHAR_MINUS;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        bcd_d = bcd_q << 4;
        rem_d = rem_q - RW'(1);
        if (started_q || (top_dig != 4'd0) || (rem_q == RW'(1))) begin
          started_d = 1'b1;
          valid_d   = 1'b1;
          char_d    = digit_char(top_dig);
          if (rem_q == RW'(1)) begin
            last_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // The sign flag rides in started_q during conversion.
    if (state_q == ST_IDLE && start && radix_mode_i == RADIX_DEC) begin
      started_d = is_neg;
    end
    if (state_q == ST_CONV && cnt_q == CW'(1)) begin
      started_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rem_q     <= '0;
      started_q <= 1'b0;
      valid_q   <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rem_q     <= rem_d;
      started_q <= started_d;
      valid_q   <= valid_d;
      last_q    <= last_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
  end

  assign busy         = (state_q != ST_IDLE);
  assign valid_o      = valid_q;
  assign ascii_char_o = char_q;
  assign last_char_o  = last_q;

  // Checks.
  `ITAD_ASSERT_IMP(a_last_has_valid, last_char_o, valid_o)
  `ITAD_ASSERT_NXT(a_idle_no_word, !busy, !valid_o)
  `ITAD_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `ITAD_ASSERT_IMP(a_last_frees, valid_o && last_char_o, !busy)

endmodule
`default_nettype wire

FILE: rtl/itad_dd_step.sv
// One shift-and-add-3 step of the binary to BCD converter.
`default_nettype none
module itad_dd_step #(
  parameter int unsigned NDIG = 10
) (
  input  wire logic [4*NDIG-1:0] bcd_i,
  input  wire logic              bit_i,
  output logic      [4*NDIG-1:0] bcd_o
);
  import itad_pkg::*;

  logic [4*NDIG-1:0] adj;

  // Digits at 5 or above get +3 so the shift carries into the next digit.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_i[4*i +: 4] >= BCD_ADJ_LIMIT) begin
        adj[4*i +: 4] = bcd_i[4*i +: 4] + BCD_ADJ;
      end else begin
        adj[4*i +: 4] = bcd_i[4*i +: 4];
      end
    end
  end

  assign bcd_o = {adj[4*NDIG-2:0], bit_i};

endmodule
`default_nettype wire

FILE: sim/tb_int_to_ascii_dec_hex.sv
// Self-checking testbench for the binary to ASCII decimal/hex converter.
`default_nettype none
module tb_int_to_ascii_dec_hex;
  timeunit 1ns;
  timeprecision 1ps;

  import itad_pkg::*;

  localparam int N_RANDOM     = 136;
  localparam int N_QUIET      = 30;    // final random words sent with no gaps
  localparam int N_DIRECTED   = 24;
  localparam int STALL_LIMIT  = 2000;  // cycles with no word or character moving
  localparam int DRAIN_CYCLES = 64;    // longer than one decimal conversion
  localparam int MAX_REPORTS  = 10;

  // One expected output character
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } ascii_chr_t;

  // Directed stimulus; an empty text means the expected string is computed
  typedef struct {
    logic [31:0] word;
    logic        mode;
    string       text;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] value_i = '0;
  logic        radix_mode_i = RADIX_DEC;
  logic        valid_o;
  logic [7:0]  ascii_char_o;
  logic        last_char_o;

  ascii_chr_t char_q[$];
  string      hex_syms = "0123456789abcdef";
  int         n_errors = 0;
  int         n_words = 0;
  int         n_chars = 0;
  int         n_neg = 0;
  int         n_hex = 0;
  int         stall_cycles = 0;

  dir_row_t dir_tab [N_DIRECTED] = '{
    '{32'h0000_0000, RADIX_DEC, "0"},
    '{32'h0000_0000, RADIX_HEX, "0"},
    '{32'h8000_0000, RADIX_DEC, "-2147483648"},
    '{32'h7fff_ffff, RADIX_DEC, "2147483647"},
    '{32'hffff_ffff, RADIX_DEC, "-1"},
    '{32'hffff_ffff, RADIX_HEX, "ffffffff"},
    '{32'h8000_0000, RADIX_HEX, "80000000"},
    '{32'h0000_0001, RADIX_DEC, "1"},
    '{32'h0000_0001, RADIX_HEX, "1"},
    '{32'h0000_0009, RADIX_DEC, "9"},
    '{32'h0000_000a, RADIX_DEC, "10"},
    '{32'hffff_fff6, RADIX_DEC, "-10"},
    '{32'h0000_000f, RADIX_HEX, "f"},
    '{32'h0000_0010, RADIX_HEX, "10"},
    '{32'h0000_000a, RADIX_HEX, "a"},
    '{32'hdead_beef, RADIX_HEX, "deadbeef"},
    '{32'h3b9a_ca00, RADIX_DEC, "1000000000"},
    '{32'hc465_3600, RADIX_DEC, "-1000000000"},
    '{32'h7fff_ffff, RADIX_HEX, "7fffffff"},
    '{32'h5555_5555, RADIX_HEX, "55555555"},
    '{32'h1234_5678, RADIX_DEC, ""},
    '{32'h8765_4321, RADIX_DEC, ""},
    '{32'habcd_ef01, RADIX_HEX, ""},
    '{32'haaaa_aaaa, RADIX_DEC, ""}
  };

  int_to_ascii_dec_hex DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .value_i      (value_i),
    .radix_mode_i (radix_mode_i),
    .valid_o      (valid_o),
    .ascii_char_o (ascii_char_o),
    .last_char_o  (last_char_o)
  );

  always #2 clk_i = ~clk_i;

  // Queue the characters of a literal string, flagging the final one
  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      char_q.push_back('{ch: s[i], last: (i == s.len() - 1)});
    end
  endfunction

  // Render a word as decimal (two's complement) or lowercase hex text
  function automatic string render_word(input logic [31:0] word, input logic mode);
    logic [31:0] mag;
    string       txt;
    txt = "";
    mag = word;
    if (mode == RADIX_DEC) begin
      // negate in 32 bits: the most negative value stays 2^31 as unsigned
      if (word[31]) mag = 32'd0 - word;
      do begin
        txt = {string'(8'("0" + mag % 10)), txt};
        mag = mag / 10;
      end while (mag != 0);
      if (word[31]) txt = {"-", txt};
    end else begin
      do begin
        txt = {string'(hex_syms[mag[3:0]]), txt};
        mag = mag >> 4;
      end while (mag != 0);
    end
    return txt;
  endfunction

  // Random word biased toward digit-count boundaries and short strings
  function automatic logic [31:0] pick_word();
    logic [31:0] v;
    int unsigned p;
    p = 1;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 20);
      2: v = 32'd0 - 32'($urandom_range(1, 20));
      3: begin
        repeat ($urandom_range(0, 9)) p = p * 10;
        v = p + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
      end
      4: v = (32'd1 << $urandom_range(0, 31)) - 32'($urandom_range(0, 1));
      default: v = $urandom() >> $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  // Offer one word, optionally after an idle burst, and wait for it to be taken
  task automatic issue_word(input logic [31:0] w, input logic m, input string text,
                            input bit allow_gap);
    if (allow_gap && $urandom_range(0, 1) == 1) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start        <= 1'b1;
    value_i      <= w;
    radix_mode_i <= m;
    do @(posedge clk_i); while (busy);
    queue_text((text.len() > 0) ? text : render_word(w, m));
    n_words++;
    if (m == RADIX_HEX) n_hex++;
    else if (w[31]) n_neg++;
  endtask

  // Stimulus: directed table, then random words, then drain
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tab[i]) begin
      issue_word(dir_tab[i].word, dir_tab[i].mode, dir_tab[i].text, 1'b1);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      issue_word(pick_word(), logic'($urandom_range(0, 1)), "", i < N_RANDOM - N_QUIET);
    end
    start <= 1'b0;
    while (char_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Converted %0d words (%0d hex, %0d negative decimal) into %0d characters.",
             n_words, n_hex, n_neg, n_chars);
    if (n_errors == 0 && char_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Character checker: each strobed character against the oldest expectation
  always @(posedge clk_i) begin
    ascii_chr_t want;
    if (rst_ni && valid_o) begin
      n_chars++;
      if (char_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: unexpected character 0x%02h last=%0b",
                   $realtime, ascii_char_o, last_char_o);
      end else begin
        want = char_q.pop_front();
        if (ascii_char_o !== want.ch || last_char_o !== want.last) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: char exp 0x%02h last=%0b, got 0x%02h last=%0b",
                     $realtime, want.ch, want.last, ascii_char_o, last_char_o);
        end
      end
    end
  end

  // Watchdog: nothing moving for too long ends the run
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout with %0d characters outstanding", $realtime, char_q.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
`default_nettype wire
